>>> hdl/gpp_pkg.sv
// shared types and constants for the gtp-u header parser
`timescale 1ns / 1ps
package gpp_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP     = 8'd17;
    localparam logic [7:0]  GTP_MSG_GPDU     = 8'hff;
    localparam logic [7:0]  EXT_PDU_SESSION  = 8'h85;
    localparam logic [7:0]  EXT_LEN_MAX      = 8'd64;
    localparam logic [15:0] PORT_PRIMARY_RST = 16'd2152;
    localparam logic [15:0] PORT_ALT_RST     = 16'd2153;
    localparam int          CFG_INDEX_W      = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_PRIMARY   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_ALTERNATE = 8'd1;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_gpp_in;

    // one parsed frame, everything but the running count
    typedef struct packed {
        logic [63:0] outer_addresses;
        logic [31:0] outer_ports;
        logic        is_gtpu;
        logic [7:0]  gtp_flags;
        logic [23:0] gtp_type_length;
        logic [31:0] tunnel_id;
        logic [25:0] sequence_npdu;
        logic [42:0] extension_chain;
        logic [11:0] qos_info;
        logic [63:0] inner_addresses;
        logic [8:0]  inner_info;
    } t_gpp_rec;

    typedef struct packed {
        logic [63:0] outer_addresses;
        logic [31:0] outer_ports;
        logic        is_gtpu;
        logic [7:0]  gtp_flags;
        logic [23:0] gtp_type_length;
        logic [31:0] tunnel_id;
        logic [25:0] sequence_npdu;
        logic [42:0] extension_chain;
        logic [11:0] qos_info;
        logic [63:0] inner_addresses;
        logic [8:0]  inner_info;
        logic [31:0] packet_count;
    } t_gpp_out;

endpackage

>>> hdl/gpp_front.sv
// byte-wise frame parser: walks the headers and builds one record per IPv4/UDP frame
`timescale 1ns / 1ps
module gpp_front #(
    parameter int MAX_EXTENSIONS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  gpp_pkg::t_gpp_in              i_data,
    input  logic                          i_cfg_we,
    input  logic [gpp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output logic                          o_push,
    output gpp_pkg::t_gpp_rec             o_rec
);
    import gpp_pkg::*;

    localparam int WW = $clog2(MAX_EXTENSIONS + 1);

    typedef enum logic [3:0] {
        PH_ETH, PH_IP, PH_IPOPT, PH_UDP, PH_GTP, PH_OPT, PH_EXT, PH_INNER, PH_DONE, PH_DROP
    } t_phase;

    logic [15:0]   r_port_pri, r_port_alt;
    t_phase        r_phase, n_phase;
    logic [15:0]   r_pos, n_pos, r_sect, n_sect;
    logic [5:0]    r_ohl, n_ohl;
    logic [7:0]    r_pend, n_pend;
    logic [8:0]    r_elen, n_elen;
    logic [WW-1:0] r_walked, n_walked;
    logic [63:0]   r_shift, n_shift;
    logic [63:0]   r_oaddr, n_oaddr;
    logic [31:0]   r_oports, n_oports;
    logic [8:0]    r_flags, n_flags;
    logic [23:0]   r_typelen, n_typelen;
    logic [31:0]   r_teid, n_teid;
    logic [25:0]   r_seq, n_seq;
    logic [7:0]    r_ext_first, n_ext_first;
    logic [3:0][7:0] r_slots, n_slots;
    logic [11:0]   r_qos, n_qos;
    logic [63:0]   r_iaddr, n_iaddr;
    logic [8:0]    r_iinfo, n_iinfo;

    logic [7:0]    b;
    logic [15:0]   rel, pos_next;
    logic [16:0]   rel_p1;
    logic [63:0]   s;
    logic          hit;
    logic [2:0]    walked_sat;
    logic          inner_ok, emit;

    assign b        = i_data.frame_byte;
    assign rel      = 16'(r_pos - r_sect);
    assign rel_p1   = {1'b0, rel} + 17'd1;
    assign pos_next = 16'(r_pos + 16'd1);
    assign s        = {r_shift[55:0], b};
    assign hit = (r_oports[31:16] == r_port_pri) || (r_oports[31:16] == r_port_alt) ||
                 (r_oports[15:0] == r_port_pri) || (r_oports[15:0] == r_port_alt);

    always_comb begin
        n_phase = r_phase;   n_sect = r_sect;     n_ohl = r_ohl;
        n_pend = r_pend;     n_elen = r_elen;     n_walked = r_walked;
        n_shift = r_shift;   n_oaddr = r_oaddr;   n_oports = r_oports;
        n_flags = r_flags;   n_typelen = r_typelen; n_teid = r_teid;
        n_seq = r_seq;       n_ext_first = r_ext_first; n_slots = r_slots;
        n_qos = r_qos;       n_iaddr = r_iaddr;   n_iinfo = r_iinfo;
        n_pos = (r_pos != 16'hffff) ? pos_next : r_pos;
        unique case (r_phase)
            PH_ETH: begin
                n_shift = s;
                if (r_pos == 16'd13) begin
                    if (s[15:0] != ETHERTYPE_IPV4) begin
                        n_phase = PH_DROP;
                    end else begin
                        n_phase = PH_IP;
                        n_sect  = 16'd14;
                    end
                end
            end
            PH_IP: begin
                if (rel == 16'd0) n_ohl = {b[3:0], 2'b00};
                if (rel == 16'd9 && b != IP_PROTO_UDP) begin
                    n_phase = PH_DROP;
                end else begin
                    if (rel >= 16'd12) n_oaddr = {r_oaddr[55:0], b};
                    if (rel == 16'd19) begin
                        if (r_ohl < 6'd20) begin
                            n_phase = PH_DROP;
                        end else if (r_ohl == 6'd20) begin
                            n_phase = PH_UDP;
                            n_sect  = pos_next;
                        end else begin
                            n_phase = PH_IPOPT;
                        end
                    end
                end
            end
            PH_IPOPT: begin
                if (rel_p1 == 17'(r_ohl)) begin
                    n_phase = PH_UDP;
                    n_sect  = pos_next;
                end
            end
            PH_UDP: begin
                if (rel < 16'd4) n_oports = {r_oports[23:0], b};
                if (rel == 16'd7) begin
                    n_phase = PH_GTP;
                    n_sect  = pos_next;
                    n_shift = '0;
                end
            end
            PH_GTP: begin
                n_shift = s;
                if (rel == 16'd7) begin
                    n_sect  = pos_next;
                    n_shift = '0;
                    if (!hit || s[63:61] != 3'd1 || !s[60] || s[55:48] != GTP_MSG_GPDU) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_flags   = {1'b1, s[63:60], 1'b0, s[58:56]};
                        n_typelen = s[55:32];
                        n_teid    = s[31:0];
                        n_phase   = (s[58:56] != 3'd0) ? PH_OPT : PH_INNER;
                    end
                end
            end
            PH_OPT: begin
                n_shift = s;
                if (rel == 16'd3) begin
                    n_seq = {r_flags[1], r_flags[1] ? s[31:16] : 16'd0,
                             r_flags[0], r_flags[0] ? s[15:8] : 8'd0};
                    n_ext_first = b;
                    n_pend      = b;
                    n_sect      = pos_next;
                    n_phase     = (r_flags[2] && b != 8'd0) ? PH_EXT : PH_INNER;
                end
            end
            PH_EXT: begin
                if (rel == 16'd0) begin
                    if (b == 8'd0 || b > EXT_LEN_MAX) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_elen = {b[6:0], 2'b00};
                        // oldest walked type sits in the top slot
                        if (int'(r_walked) < 4) n_slots[2'(3 - int'(r_walked))] = r_pend;
                        n_walked = WW'(r_walked + 1'b1);
                    end
                end else begin
                    if (r_pend == EXT_PDU_SESSION) begin
                        if (rel == 16'd1) n_shift = {56'd0, b};
                        if (rel == 16'd2) n_qos = {1'b1, r_shift[7:4], 1'b1, b[5:0]};
                    end
                    if (rel_p1 == 17'(r_elen)) begin
                        n_pend = b;
                        n_sect = pos_next;
                        if (b == 8'd0) begin
                            n_phase = PH_INNER;
                        end else if (int'(r_walked) < MAX_EXTENSIONS) begin
                            n_phase = PH_EXT;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
            end
            PH_INNER: begin
                if (rel == 16'd0) begin
                    if (b[7:4] != 4'd4 || b[3:0] < 4'd5) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_elen = {3'd0, b[3:0], 2'b00};
                    end
                end else begin
                    if (rel == 16'd9) n_pend = b;
                    if (rel >= 16'd12 && rel <= 16'd19) n_iaddr = {r_iaddr[55:0], b};
                    if (rel_p1 == 17'(r_elen)) begin
                        n_iinfo = {1'b1, r_pend};
                        n_phase = PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign walked_sat = (int'(n_walked) > 7) ? 3'd7 : 3'(n_walked);
    assign inner_ok   = n_iinfo[8];
    assign emit = n_phase == PH_GTP || n_phase == PH_OPT || n_phase == PH_EXT ||
                  n_phase == PH_INNER || n_phase == PH_DONE;

    always_comb begin
        o_push = i_accept && i_data.frame_end && emit;
        o_rec.outer_addresses = n_oaddr;
        o_rec.outer_ports     = n_oports;
        o_rec.is_gtpu         = n_flags[8];
        o_rec.gtp_flags       = n_flags[7:0];
        o_rec.gtp_type_length = n_typelen;
        o_rec.tunnel_id       = n_teid;
        o_rec.sequence_npdu   = n_seq;
        o_rec.extension_chain = {n_ext_first, n_flags[8] ? walked_sat : 3'd0, n_slots};
        o_rec.qos_info        = n_qos;
        o_rec.inner_addresses = inner_ok ? n_iaddr : 64'd0;
        o_rec.inner_info      = inner_ok ? n_iinfo : 9'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_pri <= PORT_PRIMARY_RST;
            r_port_alt <= PORT_ALT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PORT_PRIMARY) r_port_pri <= i_cfg_data;
            if (i_cfg_index == CFG_PORT_ALTERNATE) r_port_alt <= i_cfg_data;
        end
    end

    // per-frame state returns to its start values after every last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_data.frame_end)) begin
            r_phase <= PH_ETH;  r_pos <= '0;    r_sect <= '0;   r_ohl <= '0;
            r_pend <= '0;       r_elen <= '0;   r_walked <= '0; r_shift <= '0;
            r_oaddr <= '0;      r_oports <= '0; r_flags <= '0;  r_typelen <= '0;
            r_teid <= '0;       r_seq <= '0;    r_ext_first <= '0; r_slots <= '0;
            r_qos <= '0;        r_iaddr <= '0;  r_iinfo <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase; r_pos <= n_pos;       r_sect <= n_sect;
            r_ohl <= n_ohl;     r_pend <= n_pend;     r_elen <= n_elen;
            r_walked <= n_walked; r_shift <= n_shift; r_oaddr <= n_oaddr;
            r_oports <= n_oports; r_flags <= n_flags; r_typelen <= n_typelen;
            r_teid <= n_teid;   r_seq <= n_seq;       r_ext_first <= n_ext_first;
            r_slots <= n_slots; r_qos <= n_qos;       r_iaddr <= n_iaddr;
            r_iinfo <= n_iinfo;
        end
    end

endmodule

>>> hdl/gpp_queue.sv
// two-entry record queue between the parser and the output stage
`timescale 1ns / 1ps
module gpp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gpp_pkg::t_gpp_rec i_rec,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output gpp_pkg::t_gpp_rec o_rec
);
    import gpp_pkg::*;

    t_gpp_rec   r_entry [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rec   = r_entry[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = 2'(r_cnt + 2'd1);
        if (!i_push && i_pop) n_cnt = 2'(r_cnt - 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_entry[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> hdl/gpp_back.sv
// output stage: frame totals and the registered result word
`timescale 1ns / 1ps
module gpp_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  gpp_pkg::t_gpp_rec i_rec,
    input  logic              i_stall,
    output logic              o_pop,
    output logic              o_valid,
    output gpp_pkg::t_gpp_out o_data
);
    import gpp_pkg::*;

    logic [COUNT_WIDTH-1:0] r_gtpu_total, r_other_total, n_total;
    logic                   r_valid;
    t_gpp_out               r_data;

    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign n_total = i_rec.is_gtpu ? COUNT_WIDTH'(r_gtpu_total + 1'b1)
                                   : COUNT_WIDTH'(r_other_total + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_gtpu_total  <= '0;
            r_other_total <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (i_rec.is_gtpu) r_gtpu_total <= n_total;
                else r_other_total <= n_total;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data.outer_addresses <= i_rec.outer_addresses;
            r_data.outer_ports     <= i_rec.outer_ports;
            r_data.is_gtpu         <= i_rec.is_gtpu;
            r_data.gtp_flags       <= i_rec.gtp_flags;
            r_data.gtp_type_length <= i_rec.gtp_type_length;
            r_data.tunnel_id       <= i_rec.tunnel_id;
            r_data.sequence_npdu   <= i_rec.sequence_npdu;
            r_data.extension_chain <= i_rec.extension_chain;
            r_data.qos_info        <= i_rec.qos_info;
            r_data.inner_addresses <= i_rec.inner_addresses;
            r_data.inner_info      <= i_rec.inner_info;
            r_data.packet_count    <= 32'(n_total);
        end
    end

endmodule

>>> hdl/gtpu_packet_header_parser_core.sv
// top level of the gtp-u header parser
`timescale 1ns / 1ps
// Frame bytes enter on the input channel (i_valid / o_stall), one word per
// cycle while o_stall is low, frame_end marking the last byte of each
// Ethernet frame. For every IPv4/UDP frame whose outer headers arrived
// complete, one record leaves on the output channel (o_valid / i_stall)
// carrying outer addresses and ports, the GTP-U classification, TEID,
// optional fields, extension chain, session QoS, inner IPv4 info and the
// updated GTP-U or other-UDP frame total. Throughput: one byte per cycle
// while o_stall is low; the byte parser handles each word in the cycle it
// is accepted. The parser writes each record into the two-entry queue at
// the edge that takes the last byte; the queue then loads the output
// register whenever that register holds no result or is not stalled.
// When the receiver stalls, the output register holds; the queue absorbs two
// records and only then o_stall rises, so a stall backs up per frame, not per
// byte. The port registers are written through i_cfg_valid / o_cfg_ready
// (always ready), index 0 primary port, 1 alternate port, others ignored.
// Reset (i_rst_n low, synchronous) clears the parser, queue, totals and the
// output valid, and loads the port registers with 2152 and 2153.
module gtpu_packet_header_parser_core #(
    parameter int MAX_EXTENSIONS = 4,
    parameter int COUNT_WIDTH    = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  gpp_pkg::t_gpp_in                i_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output gpp_pkg::t_gpp_out               o_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gpp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import gpp_pkg::*;

    logic     accept, push, pop, full, empty;
    t_gpp_rec front_rec, queue_rec;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;
    assign accept      = i_valid && !full;

    gpp_front #(.MAX_EXTENSIONS(MAX_EXTENSIONS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_rec       (front_rec)
    );

    gpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_rec   (queue_rec)
    );

    gpp_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_rec   (queue_rec),
        .i_stall (i_stall),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

>>> hdl/gpp_checker.sv
// port-level checks for the gtp-u header parser, bound to the top level
`timescale 1ns / 1ps
module gpp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input gpp_pkg::t_gpp_out o_data
);
    import gpp_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    a_plain_udp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.is_gtpu |-> o_data.tunnel_id == 32'd0 &&
        o_data.gtp_flags == 8'd0 && o_data.inner_info == 9'd0)
        else $error("gtp fields set on a non gtp-u record");

    a_gpdu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.is_gtpu |-> o_data.gtp_flags[7:5] == 3'd1 &&
        o_data.gtp_flags[4] && !o_data.gtp_flags[3] &&
        o_data.gtp_type_length[23:16] == GTP_MSG_GPDU)
        else $error("gtp-u record without a g-pdu base header");

    a_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.inner_info[8] |-> o_data.inner_addresses == 64'd0)
        else $error("inner addresses without an inner header");

endmodule

bind gtpu_packet_header_parser_core gpp_checker u_gpp_checker (.*);
